@@ hdl/sfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere facet subdivider package
// Shared constants and types for the subdivider datapath.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int COORD_W       = 16;
   localparam int NUM_LANES     = 9;
   localparam int NUM_MIDS      = 3;
   localparam int SQ_W          = 32;

   localparam logic [1:0] TRI_FIRST  = 2'd0;
   localparam logic [1:0] TRI_SECOND = 2'd1;
   localparam logic [1:0] TRI_THIRD  = 2'd2;
   localparam logic [1:0] TRI_CENTRE = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic [NUM_LANES-1:0] neg;
      logic [NUM_MIDS-1:0]  zero;
   } ctl_type;

endpackage
`default_nettype wire

@@ hdl/sphere_facet_subdivider_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere facet subdivider
// Splits a unit sphere triangle at its normalised edge midpoints.
// The first triangle is valid once the word has passed the input register, the
// midpoint register, one cell per quotient bit and the output stage. Each word
// yields four output words; the pipeline stalls while those are still unsent.
// Reset clears all valid flags and the output count; data is not reset.
// ----------------------------------------------------------------------------
module sphere_facet_subdivider_core #(
   parameter int COORD_FRAC_BITS = sfs_pkg::FRAC_BITS_DEF
) (
   input  wire  logic clock,
   input  wire  logic reset,
   input  wire  logic req_tvalid,
   output logic req_tready,
   // corner_a x,y,z; corner_b x,y,z; corner_c x,y,z
   input  wire  logic [143:0] req_tdata,
   output logic rsp_tvalid,
   input  wire  logic rsp_tready,
   // out_first x,y,z; out_second x,y,z; out_third x,y,z
   output logic [143:0] rsp_tdata,
   output logic rsp_tlast
);
   localparam int F  = COORD_FRAC_BITS;
   localparam int LW = 2*F+37;
   localparam int NL = sfs_pkg::NUM_LANES;
   localparam int NM = sfs_pkg::NUM_MIDS;
   localparam int CW = sfs_pkg::COORD_W;

   logic en, take;
   logic in_valid_ff;
   logic [NL-1:0][CW-1:0] in_ff, mid_m;
   logic [NL-1:0][sfs_pkg::SQ_W-1:0] m2;
   logic [NM-1:0][sfs_pkg::SQ_W-1:0] s_v;

   sfs_pkg::ctl_type      ctl_ch [0:F+1];
   logic [NL-1:0][CW-1:0] corner_ch [0:F+1];
   logic [NM-1:0][sfs_pkg::SQ_W-1:0] s_ch [0:F+1];
   logic [NL-1:0][LW-1:0] rhs_ch [0:F+1];
   logic [NL-1:0][F:0]    q_ch [0:F+1];
   logic [NL-1:0][LW-1:0] qs_ch [0:F+1];
   logic [NL-1:0][LW-1:0] q2s_ch [0:F+1];

   sfs_pkg::ctl_type      ctl_b_ff;
   logic [NL-1:0][CW-1:0] corner_b_ff;
   logic [NM-1:0][sfs_pkg::SQ_W-1:0] s_b_ff;
   logic [NL-1:0][sfs_pkg::SQ_W-1:0] m2_b_ff;

   assign en         = !ctl_ch[F+1].valid || take;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_tdata;
      end
   end

   for (genvar k = 0; k < NL; k++) begin : g_mid
      localparam int P = k / 3;
      localparam int R = (P + 1) % 3;
      localparam int C = k % 3;
      logic signed [CW:0] sum;
      logic [CW-1:0] mag;
      always_comb begin
         sum      = {in_ff[P*3+C][CW-1], in_ff[P*3+C]} + {in_ff[R*3+C][CW-1], in_ff[R*3+C]};
         mid_m[k] = sum[CW:1];
         mag      = mid_m[k][CW-1] ? CW'(0) - mid_m[k] : mid_m[k];
         m2[k]    = sfs_pkg::SQ_W'(mag) * sfs_pkg::SQ_W'(mag);
      end
   end

   for (genvar j = 0; j < NM; j++) begin : g_sum
      assign s_v[j] = m2[3*j] + m2[3*j+1] + m2[3*j+2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_b_ff.valid <= in_valid_ff;
      end
      if (en) begin
         corner_b_ff <= in_ff;
         m2_b_ff     <= m2;
         s_b_ff      <= s_v;
         for (int k = 0; k < NL; k++) begin
            ctl_b_ff.neg[k] <= mid_m[k][CW-1];
         end
         for (int j = 0; j < NM; j++) begin
            ctl_b_ff.zero[j] <= (s_v[j] == '0);
         end
      end
   end

   assign ctl_ch[0]    = ctl_b_ff;
   assign corner_ch[0] = corner_b_ff;
   assign s_ch[0]      = s_b_ff;
   assign q_ch[0]      = '0;
   assign qs_ch[0]     = '0;
   assign q2s_ch[0]    = '0;
   for (genvar k = 0; k < NL; k++) begin : g_rhs
      assign rhs_ch[0][k] = LW'(m2_b_ff[k]) << (2*F+2);
   end

   for (genvar i = 0; i <= F; i++) begin : g_cell
      sfs_cell #(.FRAC(F), .BIT(F-i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctl_in    (ctl_ch[i]),
         .corner_in (corner_ch[i]),
         .s_in      (s_ch[i]),
         .rhs_in    (rhs_ch[i]),
         .q_in      (q_ch[i]),
         .qs_in     (qs_ch[i]),
         .q2s_in    (q2s_ch[i]),
         .ctl_out   (ctl_ch[i+1]),
         .corner_out(corner_ch[i+1]),
         .s_out     (s_ch[i+1]),
         .rhs_out   (rhs_ch[i+1]),
         .q_out     (q_ch[i+1]),
         .qs_out    (qs_ch[i+1]),
         .q2s_out   (q2s_ch[i+1])
      );
   end

   sfs_emit #(.FRAC(F)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_ch[F+1]),
      .corner_in (corner_ch[F+1]),
      .q_in      (q_ch[F+1]),
      .take      (take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );
endmodule
`default_nettype wire

@@ hdl/sfs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subdivider root cell
// Decides one quotient bit of every normalised coordinate and passes on.
// ----------------------------------------------------------------------------
module sfs_cell #(
   parameter int FRAC = sfs_pkg::FRAC_BITS_DEF,
   parameter int BIT  = sfs_pkg::FRAC_BITS_DEF
) (
   input  wire  logic clock,
   input  wire  logic reset,
   input  wire  logic en,
   input  wire  sfs_pkg::ctl_type ctl_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][sfs_pkg::COORD_W-1:0] corner_in,
   input  wire  logic [sfs_pkg::NUM_MIDS-1:0][sfs_pkg::SQ_W-1:0] s_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][2*FRAC+36:0] rhs_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][FRAC:0] q_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][2*FRAC+36:0] qs_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][2*FRAC+36:0] q2s_in,
   output sfs_pkg::ctl_type ctl_out,
   output logic [sfs_pkg::NUM_LANES-1:0][sfs_pkg::COORD_W-1:0] corner_out,
   output logic [sfs_pkg::NUM_MIDS-1:0][sfs_pkg::SQ_W-1:0] s_out,
   output logic [sfs_pkg::NUM_LANES-1:0][2*FRAC+36:0] rhs_out,
   output logic [sfs_pkg::NUM_LANES-1:0][FRAC:0] q_out,
   output logic [sfs_pkg::NUM_LANES-1:0][2*FRAC+36:0] qs_out,
   output logic [sfs_pkg::NUM_LANES-1:0][2*FRAC+36:0] q2s_out
);
   localparam int LW = 2*FRAC+37;
   localparam int QW = FRAC+1;

   sfs_pkg::ctl_type ctl_ff;
   logic [sfs_pkg::NUM_LANES-1:0][sfs_pkg::COORD_W-1:0] corner_ff;
   logic [sfs_pkg::NUM_MIDS-1:0][sfs_pkg::SQ_W-1:0] s_ff;
   logic [sfs_pkg::NUM_LANES-1:0][LW-1:0] rhs_ff, qs_ff, q2s_ff, qs_in_v, q2s_in_v;
   logic [sfs_pkg::NUM_LANES-1:0][QW-1:0] q_ff, q_in_v;

   for (genvar k = 0; k < sfs_pkg::NUM_LANES; k++) begin : g_lane
      localparam int J = k / 3;
      logic [LW-1:0] s_ext, qs_c, q2s_c, lhs;
      logic          cap, ok;
      always_comb begin
         s_ext = LW'(s_in[J]);
         qs_c  = qs_in[k] + (s_ext << BIT);
         q2s_c = q2s_in[k] + (qs_in[k] << (BIT+1)) + (s_ext << (2*BIT));
         lhs   = (q2s_c << 2) - (qs_c << 2) + s_ext;
         cap   = (BIT == FRAC) ? 1'b1 : ~q_in[k][FRAC];
         ok    = cap && (lhs <= rhs_in[k]);
         q_in_v[k]   = ok ? (q_in[k] | (QW'(1) << BIT)) : q_in[k];
         qs_in_v[k]  = ok ? qs_c : qs_in[k];
         q2s_in_v[k] = ok ? q2s_c : q2s_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.neg  <= ctl_in.neg;
         ctl_ff.zero <= ctl_in.zero;
         corner_ff   <= corner_in;
         s_ff        <= s_in;
         rhs_ff      <= rhs_in;
         q_ff        <= q_in_v;
         qs_ff       <= qs_in_v;
         q2s_ff      <= q2s_in_v;
      end
   end

   assign ctl_out    = ctl_ff;
   assign corner_out = corner_ff;
   assign s_out      = s_ff;
   assign rhs_out    = rhs_ff;
   assign q_out      = q_ff;
   assign qs_out     = qs_ff;
   assign q2s_out    = q2s_ff;
endmodule
`default_nettype wire

@@ hdl/sfs_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subdivider output stage
// Holds one finished set of vertices and sends its four triangles in turn.
// ----------------------------------------------------------------------------
module sfs_emit #(
   parameter int FRAC = sfs_pkg::FRAC_BITS_DEF
) (
   input  wire  logic clock,
   input  wire  logic reset,
   input  wire  sfs_pkg::ctl_type ctl_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][sfs_pkg::COORD_W-1:0] corner_in,
   input  wire  logic [sfs_pkg::NUM_LANES-1:0][FRAC:0] q_in,
   output logic take,
   output logic rsp_tvalid,
   input  wire  logic rsp_tready,
   output logic [143:0] rsp_tdata, // first x,y,z; second x,y,z; third x,y,z
   output logic rsp_tlast
);
   logic [sfs_pkg::NUM_LANES-1:0][sfs_pkg::COORD_W-1:0] corner_ff, mid_ff, mid_in;
   logic        full_ff, full_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [47:0] va, vb, vc, vab, vbc, vca;

   for (genvar k = 0; k < sfs_pkg::NUM_LANES; k++) begin : g_res
      localparam int J = k / 3;
      logic [sfs_pkg::COORD_W-1:0] qt;
      always_comb begin
         qt = sfs_pkg::COORD_W'(q_in[k]);
         if (ctl_in.zero[J]) begin
            mid_in[k] = '0;
         end else if (ctl_in.neg[k]) begin
            mid_in[k] = sfs_pkg::COORD_W'(0) - qt;
         end else begin
            mid_in[k] = qt;
         end
      end
   end

   always_comb begin
      take    = ctl_in.valid && (!full_ff || (rsp_tready && cnt_ff == sfs_pkg::TRI_CENTRE));
      full_in = full_ff;
      cnt_in  = cnt_ff;
      if (full_ff && rsp_tready) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == sfs_pkg::TRI_CENTRE) begin
            full_in = 1'b0;
         end
      end
      if (take) begin
         full_in = 1'b1;
         cnt_in  = sfs_pkg::TRI_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         cnt_ff  <= sfs_pkg::TRI_FIRST;
      end else begin
         full_ff <= full_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         corner_ff <= corner_in;
         mid_ff    <= mid_in;
      end
   end

   assign va  = {corner_ff[2], corner_ff[1], corner_ff[0]};
   assign vb  = {corner_ff[5], corner_ff[4], corner_ff[3]};
   assign vc  = {corner_ff[8], corner_ff[7], corner_ff[6]};
   assign vab = {mid_ff[2], mid_ff[1], mid_ff[0]};
   assign vbc = {mid_ff[5], mid_ff[4], mid_ff[3]};
   assign vca = {mid_ff[8], mid_ff[7], mid_ff[6]};

   always_comb begin
      case (cnt_ff)
         sfs_pkg::TRI_FIRST:  rsp_tdata = {vca, vab, va};
         sfs_pkg::TRI_SECOND: rsp_tdata = {vbc, vb, vab};
         sfs_pkg::TRI_THIRD:  rsp_tdata = {vca, vc, vbc};
         sfs_pkg::TRI_CENTRE: rsp_tdata = {vca, vbc, vab};
         default:             rsp_tdata = {vca, vbc, vab};
      endcase
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tlast  = (cnt_ff == sfs_pkg::TRI_CENTRE);

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !full_ff |-> cnt_ff == sfs_pkg::TRI_FIRST) else $error("count moved while empty");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      full_ff && !rsp_tready |=> full_ff && $stable(cnt_ff)) else $error("lost a triangle");
   a_take: assert property (@(posedge clock) disable iff (reset)
      take |=> full_ff && cnt_ff == sfs_pkg::TRI_FIRST) else $error("bad reload");
endmodule
`default_nettype wire
